// File: rtl/core/hka_pkg.sv
// shared types, constants and helper functions of the heatmap keypoint argmax block
// no dependencies; every other file of the block takes names from here
`default_nettype none

package hka_pkg;

  localparam int NUM_KEYPOINTS_DEF = 17;
  localparam int MAX_MAP_DIM_DEF   = 256;
  localparam int MAX_IMAGE_DIM     = 4096;

  localparam int SCORE_W = 16;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 13;
  localparam int CNT_W   = 8;
  localparam int DIM_W   = 9;
  localparam int IMG_W   = 13;
  // 255 * 4096 fits in 20 bits
  localparam int PROD_W  = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    REG_MAP_HEIGHT   = 3'd0,
    REG_MAP_WIDTH    = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_THRESHOLD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   map_height;
    logic [DIM_W-1:0]   map_width;
    logic [IMG_W-1:0]   image_width;
    logic [IMG_W-1:0]   image_height;
    logic [SCORE_W-1:0] score_threshold;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   keypoint_index;
    logic [SCORE_W-1:0] peak_score;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   row;
    logic               found;
    logic               last_keypoint;
  } kp_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_START,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // zero acts as one, oversize clamps to the largest map
  function automatic logic [DIM_W-1:0] eff_map(input logic [DIM_W-1:0] d,
                                               input int unsigned max_dim);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > max_dim) begin
      r = DIM_W'(max_dim);
    end
    return r;
  endfunction

  function automatic logic [IMG_W-1:0] eff_img(input logic [IMG_W-1:0] d);
    logic [IMG_W-1:0] r;
    r = d;
    if (32'(d) > MAX_IMAGE_DIM) begin
      r = IMG_W'(MAX_IMAGE_DIM);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hka_front.sv
// front end: one score per cycle unless q_full; tracks channel max and its position
// depends on hka_pkg; hands one record per finished channel to the queue
`default_nettype none

module hka_front #(
  parameter int NUM_KEYPOINTS = hka_pkg::NUM_KEYPOINTS_DEF,
  parameter int MAX_MAP_DIM   = hka_pkg::MAX_MAP_DIM_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire hka_pkg::cfg_t                 cfg,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire logic signed [hka_pkg::SCORE_W-1:0] score,
  input  wire                                q_full,
  output logic                               rec_valid,
  output hka_pkg::kp_rec_t                   rec
);

  logic signed [hka_pkg::SCORE_W-1:0] best_score;
  logic [hka_pkg::CNT_W-1:0]          best_col;
  logic [hka_pkg::CNT_W-1:0]          best_row;
  logic [hka_pkg::CNT_W-1:0]          col_count;
  logic [hka_pkg::CNT_W-1:0]          row_count;
  logic [hka_pkg::IDX_W-1:0]          channel_count;

  logic                               accept;
  logic [hka_pkg::DIM_W-1:0]          w;
  logic [hka_pkg::DIM_W-1:0]          h;
  logic                               first;
  logic                               take;
  logic signed [hka_pkg::SCORE_W-1:0] best_score_next;
  logic [hka_pkg::CNT_W-1:0]          best_col_next;
  logic [hka_pkg::CNT_W-1:0]          best_row_next;
  logic [hka_pkg::DIM_W-1:0]          col_inc;
  logic [hka_pkg::DIM_W-1:0]          row_inc;
  logic [hka_pkg::IDX_W:0]            ch_inc;
  logic                               row_end;
  logic                               chan_end;
  logic                               last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w = hka_pkg::eff_map(cfg.map_width, MAX_MAP_DIM);
    h = hka_pkg::eff_map(cfg.map_height, MAX_MAP_DIM);
    first = (col_count == '0) && (row_count == '0);
    // strict compare keeps the first maximum
    take = first || (score > best_score);
    best_score_next = take ? score : best_score;
    best_col_next   = take ? col_count : best_col;
    best_row_next   = take ? row_count : best_row;
    col_inc  = {1'b0, col_count} + hka_pkg::DIM_W'(1);
    row_inc  = {1'b0, row_count} + hka_pkg::DIM_W'(1);
    ch_inc   = {1'b0, channel_count} + (hka_pkg::IDX_W+1)'(1);
    row_end  = (col_inc >= w);
    chan_end = row_end && (row_inc >= h);
    last     = (ch_inc >= (hka_pkg::IDX_W+1)'(NUM_KEYPOINTS));
  end

  always_comb begin
    rec_valid = accept && chan_end;
    rec.keypoint_index = channel_count;
    rec.peak_score     = best_score_next;
    rec.col            = best_col_next;
    rec.row            = best_row_next;
    rec.found          = (best_score_next > $signed(cfg.score_threshold));
    rec.last_keypoint  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score    <= '0;
      best_col      <= '0;
      best_row      <= '0;
      col_count     <= '0;
      row_count     <= '0;
      channel_count <= '0;
    end else if (accept) begin
      best_score <= best_score_next;
      best_col   <= best_col_next;
      best_row   <= best_row_next;
      if (!row_end) begin
        col_count <= col_inc[hka_pkg::CNT_W-1:0];
      end else begin
        col_count <= '0;
        if (!chan_end) begin
          row_count <= row_inc[hka_pkg::CNT_W-1:0];
        end else begin
          row_count     <= '0;
          channel_count <= last ? '0 : ch_inc[hka_pkg::IDX_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hka_queue.sv
// short queue of finished-channel records between front and back
// depends on hka_pkg for the record type
`default_nettype none

module hka_queue #(
  parameter int DEPTH = hka_pkg::QUEUE_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  wire hka_pkg::kp_rec_t   push_data,
  output logic                    full,
  input  wire                     pop,
  output hka_pkg::kp_rec_t        pop_data,
  output logic                    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hka_pkg::kp_rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hka_div.sv
// restoring divider, one quotient bit per cycle
// depends on hka_pkg for default widths
`default_nettype none

module hka_div #(
  parameter int DIVIDEND_W = hka_pkg::PROD_W,
  parameter int DIVISOR_W  = hka_pkg::DIM_W
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire [DIVIDEND_W-1:0]   dividend,
  input  wire [DIVISOR_W-1:0]    divisor,
  output logic                   busy,
  output logic [DIVIDEND_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]    steps;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  // remainder stays below the divisor, so the trial value needs one extra bit
  always_comb begin
    trial = {rem, quotient[DIVIDEND_W-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  assign busy = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hka_back.sv
// back end: scales the peak position to image pixels and holds the result register
// depends on hka_pkg and hka_div
`default_nettype none

module hka_back #(
  parameter int MAX_MAP_DIM = hka_pkg::MAX_MAP_DIM_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire hka_pkg::cfg_t               cfg,
  input  wire                              rec_avail,
  input  wire hka_pkg::kp_rec_t            rec,
  output logic                             pop,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [hka_pkg::IDX_W-1:0]        keypoint_index,
  output logic [hka_pkg::SCORE_W-1:0]      peak_score,
  output logic [hka_pkg::POS_W-1:0]        pos_x,
  output logic [hka_pkg::POS_W-1:0]        pos_y,
  output logic                             found,
  output logic                             last_keypoint
);

  hka_pkg::back_state_t state;
  hka_pkg::back_state_t state_next;

  hka_pkg::kp_rec_t          job;
  logic [hka_pkg::PROD_W-1:0] prod_x;
  logic [hka_pkg::PROD_W-1:0] prod_y;
  logic [hka_pkg::PROD_W-1:0] quo_x;
  logic [hka_pkg::PROD_W-1:0] quo_y;
  logic                       busy_x;
  logic                       busy_y;
  logic                       load_prod;
  logic                       div_start;
  logic                       load_out;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      hka_pkg::BK_IDLE:  if (rec_avail) state_next = hka_pkg::BK_MUL;
      hka_pkg::BK_MUL:   state_next = hka_pkg::BK_START;
      hka_pkg::BK_START: state_next = hka_pkg::BK_DIV;
      hka_pkg::BK_DIV:   if (!busy_x && !busy_y) state_next = hka_pkg::BK_DONE;
      hka_pkg::BK_DONE:  if (out_free) state_next = hka_pkg::BK_IDLE;
      default:           state_next = hka_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load_prod = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      hka_pkg::BK_IDLE:  pop = rec_avail;
      hka_pkg::BK_MUL:   load_prod = 1'b1;
      hka_pkg::BK_START: div_start = 1'b1;
      hka_pkg::BK_DIV:   ;
      hka_pkg::BK_DONE:  load_out = out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hka_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= rec;
    end
    if (load_prod) begin
      prod_x <= hka_pkg::PROD_W'(job.col) *
                hka_pkg::PROD_W'(hka_pkg::eff_img(cfg.image_width));
      prod_y <= hka_pkg::PROD_W'(job.row) *
                hka_pkg::PROD_W'(hka_pkg::eff_img(cfg.image_height));
    end
  end

  hka_div #(
    .DIVIDEND_W(hka_pkg::PROD_W),
    .DIVISOR_W (hka_pkg::DIM_W)
  ) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod_x),
    .divisor (hka_pkg::eff_map(cfg.map_width, MAX_MAP_DIM)),
    .busy    (busy_x),
    .quotient(quo_x)
  );

  hka_div #(
    .DIVIDEND_W(hka_pkg::PROD_W),
    .DIVISOR_W (hka_pkg::DIM_W)
  ) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod_y),
    .divisor (hka_pkg::eff_map(cfg.map_height, MAX_MAP_DIM)),
    .busy    (busy_y),
    .quotient(quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // not found reports -1, all ones
  always_ff @(posedge clk) begin
    if (load_out) begin
      keypoint_index <= job.keypoint_index;
      peak_score     <= job.peak_score;
      pos_x          <= job.found ? quo_x[hka_pkg::POS_W-1:0] : '1;
      pos_y          <= job.found ? quo_y[hka_pkg::POS_W-1:0] : '1;
      found          <= job.found;
      last_keypoint  <= job.last_keypoint;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/heatmap_keypoint_argmax_top.sv
// heatmap keypoint argmax decoder, top level
//
// s_axis carries one signed Q8.8 score per request: keypoint channels in
// order, each channel row-major over map_height rows of map_width columns.
// The front takes one score per cycle while the queue is not full and keeps
// the channel maximum; the first of equal maxima wins. On the last score of a
// channel a record goes into a 4-entry queue. The back scales the peak column
// and row to image pixels with two lockstep dividers (one quotient bit per
// cycle) and puts one result on m_axis per channel; it handles one channel at
// a time: pop, multiply, start, the 20-step divide, then the output register.
// When channels arrive faster than the back finishes them, the queue fills and
// s_axis_tready drops while it is full. A stalled m_axis holds its result; the
// back then waits and the queue fills. Reset clears counters, queue and output
// valid and loads the register defaults (map 48 wide by 64 high, 640x480 image,
// threshold 0). The user must write the registers over the APB port only while
// no channel is in progress; the block itself does not enforce this.
`default_nettype none

module heatmap_keypoint_argmax_top #(
  parameter int NUM_KEYPOINTS = hka_pkg::NUM_KEYPOINTS_DEF,
  parameter int MAX_MAP_DIM   = hka_pkg::MAX_MAP_DIM_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  // apb configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [hka_pkg::ADDR_W-1:0]      paddr,
  input  wire [hka_pkg::DATA_W-1:0]      pwdata,
  output logic [hka_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // score stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [hka_pkg::SCORE_W-1:0]     s_axis_tdata,   // [15:0] score
  // result stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [5:0] keypoint_index, [21:6] peak_score, [34:22] pos_x, [47:35] pos_y
  output logic [hka_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,   // [0] found
  output logic                           m_axis_tlast    // last keypoint of frame
);

  hka_pkg::cfg_t    cfg;
  hka_pkg::kp_rec_t push_rec;
  hka_pkg::kp_rec_t head_rec;
  logic             push;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  logic             cfg_wr;

  logic [hka_pkg::IDX_W-1:0]   out_index;
  logic [hka_pkg::SCORE_W-1:0] out_score;
  logic [hka_pkg::POS_W-1:0]   out_x;
  logic [hka_pkg::POS_W-1:0]   out_y;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_height      <= hka_pkg::DIM_W'(64);
      cfg.map_width       <= hka_pkg::DIM_W'(48);
      cfg.image_width     <= hka_pkg::IMG_W'(640);
      cfg.image_height    <= hka_pkg::IMG_W'(480);
      cfg.score_threshold <= '0;
    end else if (cfg_wr) begin
      unique case (hka_pkg::reg_idx_t'(paddr[hka_pkg::ADDR_W-1:2]))
        hka_pkg::REG_MAP_HEIGHT:   cfg.map_height      <= pwdata[hka_pkg::DIM_W-1:0];
        hka_pkg::REG_MAP_WIDTH:    cfg.map_width       <= pwdata[hka_pkg::DIM_W-1:0];
        hka_pkg::REG_IMAGE_WIDTH:  cfg.image_width     <= pwdata[hka_pkg::IMG_W-1:0];
        hka_pkg::REG_IMAGE_HEIGHT: cfg.image_height    <= pwdata[hka_pkg::IMG_W-1:0];
        hka_pkg::REG_THRESHOLD:    cfg.score_threshold <= pwdata[hka_pkg::SCORE_W-1:0];
        default:                   ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (hka_pkg::reg_idx_t'(paddr[hka_pkg::ADDR_W-1:2]))
      hka_pkg::REG_MAP_HEIGHT:   prdata = hka_pkg::DATA_W'(cfg.map_height);
      hka_pkg::REG_MAP_WIDTH:    prdata = hka_pkg::DATA_W'(cfg.map_width);
      hka_pkg::REG_IMAGE_WIDTH:  prdata = hka_pkg::DATA_W'(cfg.image_width);
      hka_pkg::REG_IMAGE_HEIGHT: prdata = hka_pkg::DATA_W'(cfg.image_height);
      // threshold reads back sign extended
      hka_pkg::REG_THRESHOLD:    prdata = hka_pkg::DATA_W'($signed(cfg.score_threshold));
      default:                   prdata = '0;
    endcase
  end

  hka_front #(
    .NUM_KEYPOINTS(NUM_KEYPOINTS),
    .MAX_MAP_DIM  (MAX_MAP_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .score    ($signed(s_axis_tdata)),
    .q_full   (q_full),
    .rec_valid(push),
    .rec      (push_rec)
  );

  hka_queue #(
    .DEPTH(hka_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_data (head_rec),
    .empty    (q_empty)
  );

  hka_back #(
    .MAX_MAP_DIM(MAX_MAP_DIM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .rec_avail     (!q_empty),
    .rec           (head_rec),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .keypoint_index(out_index),
    .peak_score    (out_score),
    .pos_x         (out_x),
    .pos_y         (out_y),
    .found         (m_axis_tuser),
    .last_keypoint (m_axis_tlast)
  );

  assign m_axis_tdata = {out_y, out_x, out_score, out_index};

  // a channel record must never be dropped at the queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("channel record pushed into a full queue");

  // the back only pops a queue that holds a record
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tuser |-> (out_x == '1) && (out_y == '1))
    else $error("position not -1 on a keypoint that was not found");

  assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser |-> $signed(out_score) > $signed(cfg.score_threshold))
    else $error("found flag set on a peak at or below threshold");

  assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tlast |-> 32'(out_index) == NUM_KEYPOINTS - 1)
    else $error("last keypoint flag on the wrong channel");

endmodule

`default_nettype wire

// File: test/heatmap_keypoint_argmax_checker.sv
`timescale 1ns / 100ps
// checker for the heatmap keypoint argmax block: follows apb writes and the score stream,
// predicts one peak record per finished channel and compares it with each m_axis request
// depends on hka_pkg for register indexes and field widths
module heatmap_keypoint_argmax_checker #(
  parameter int NUM_KEYPOINTS = hka_pkg::NUM_KEYPOINTS_DEF,
  parameter int MAX_MAP_DIM   = hka_pkg::MAX_MAP_DIM_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [hka_pkg::ADDR_W-1:0]      paddr,
  input  wire [hka_pkg::DATA_W-1:0]      pwdata,
  input  wire                            pready,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  input  wire [hka_pkg::SCORE_W-1:0]     s_axis_tdata,   // [15:0] score
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [5:0] keypoint_index, [21:6] peak_score, [34:22] pos_x, [47:35] pos_y
  input  wire [hka_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire                            m_axis_tuser,   // [0] found
  input  wire                            m_axis_tlast,
  output int                             pending_peaks,
  output int                             mismatches
);
  import hka_pkg::*;

  localparam int PEAK_LSB = IDX_W;
  localparam int POSX_LSB = IDX_W + SCORE_W;
  localparam int POSY_LSB = IDX_W + SCORE_W + POS_W;

  typedef struct packed {
    logic [IDX_W-1:0]   keypoint;
    logic [SCORE_W-1:0] peak;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               found;
    logic               last_kp;
  } peak_rec_t;

  peak_rec_t peaks_due[$];

  logic [DIM_W-1:0]          rows_cfg;
  logic [DIM_W-1:0]          cols_cfg;
  logic [IMG_W-1:0]          img_w_cfg;
  logic [IMG_W-1:0]          img_h_cfg;
  logic signed [SCORE_W-1:0] thr_cfg;

  logic signed [SCORE_W-1:0] best_score;
  logic [CNT_W-1:0]          best_col;
  logic [CNT_W-1:0]          best_row;
  logic [CNT_W-1:0]          col_cnt;
  logic [CNT_W-1:0]          row_cnt;
  logic [IDX_W-1:0]          channel;

  int errors = 0;
  int results_seen = 0;

  function automatic int unsigned map_extent(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end
    if (d > MAX_MAP_DIM) begin
      return MAX_MAP_DIM;
    end
    return d;
  endfunction

  function automatic logic [POS_W-1:0] scale_to_image(input logic [CNT_W-1:0] idx,
                                                      input logic [IMG_W-1:0] img,
                                                      input logic [DIM_W-1:0] map);
    int unsigned pixels;
    pixels = (img > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : img;
    return POS_W'((32'(idx) * pixels) / map_extent(map));
  endfunction

  function automatic void track_peak(input logic signed [SCORE_W-1:0] s);
    int unsigned w;
    int unsigned h;
    peak_rec_t   rec;
    w = map_extent(cols_cfg);
    h = map_extent(rows_cfg);
    // first score of a channel always takes the peak, ties keep the earlier one
    if ((col_cnt == '0 && row_cnt == '0) || s > best_score) begin
      best_score = s;
      best_col   = col_cnt;
      best_row   = row_cnt;
    end
    // a width or height shrunk mid-channel ends the row or channel at once
    if (32'(col_cnt) + 1 < w) begin
      col_cnt = col_cnt + 1'b1;
      return;
    end
    col_cnt = '0;
    if (32'(row_cnt) + 1 < h) begin
      row_cnt = row_cnt + 1'b1;
      return;
    end
    row_cnt = '0;
    rec.keypoint = channel;
    rec.peak     = best_score;
    rec.found    = best_score > thr_cfg;
    rec.last_kp  = 32'(channel) + 1 >= NUM_KEYPOINTS;
    rec.pos_x    = '1;
    rec.pos_y    = '1;
    if (rec.found) begin
      rec.pos_x = scale_to_image(best_col, img_w_cfg, cols_cfg);
      rec.pos_y = scale_to_image(best_row, img_h_cfg, rows_cfg);
    end
    peaks_due.push_back(rec);
    channel = rec.last_kp ? '0 : channel + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                 input logic [OUT_DATA_W-1:0] want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
             $realtime, results_seen, what, got, want);
    errors++;
  endtask

  task automatic check_peak();
    peak_rec_t want;
    results_seen++;
    if (peaks_due.size() == 0) begin
      report_mismatch("result with no channel finished", m_axis_tdata, '0);
      return;
    end
    want = peaks_due.pop_front();
    if (m_axis_tdata[IDX_W-1:0] != want.keypoint) begin
      report_mismatch("keypoint_index", m_axis_tdata[IDX_W-1:0], want.keypoint);
    end
    if (m_axis_tdata[PEAK_LSB +: SCORE_W] != want.peak) begin
      report_mismatch("peak_score", m_axis_tdata[PEAK_LSB +: SCORE_W], want.peak);
    end
    if (m_axis_tdata[POSX_LSB +: POS_W] != want.pos_x) begin
      report_mismatch("pos_x", m_axis_tdata[POSX_LSB +: POS_W], want.pos_x);
    end
    if (m_axis_tdata[POSY_LSB +: POS_W] != want.pos_y) begin
      report_mismatch("pos_y", m_axis_tdata[POSY_LSB +: POS_W], want.pos_y);
    end
    if (m_axis_tuser != want.found) begin
      report_mismatch("found", m_axis_tuser, want.found);
    end
    if (m_axis_tlast != want.last_kp) begin
      report_mismatch("last_keypoint", m_axis_tlast, want.last_kp);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg   = 9'd64;
      cols_cfg   = 9'd48;
      img_w_cfg  = 13'd640;
      img_h_cfg  = 13'd480;
      thr_cfg    = '0;
      best_score = '0;
      best_col   = '0;
      best_row   = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      channel    = '0;
      peaks_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MAP_HEIGHT:   rows_cfg  = pwdata[DIM_W-1:0];
          REG_MAP_WIDTH:    cols_cfg  = pwdata[DIM_W-1:0];
          REG_IMAGE_WIDTH:  img_w_cfg = pwdata[IMG_W-1:0];
          REG_IMAGE_HEIGHT: img_h_cfg = pwdata[IMG_W-1:0];
          REG_THRESHOLD:    thr_cfg   = pwdata[SCORE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_peak(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_peak();
      end
    end
    pending_peaks <= peaks_due.size();
    mismatches    <= errors;
  end

endmodule

// File: test/heatmap_keypoint_argmax_top_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for heatmap_keypoint_argmax_top: apb register settings, score channels
// and random ready on the result side; needs hka_pkg and heatmap_keypoint_argmax_checker
module heatmap_keypoint_argmax_top_test;
  import hka_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_SCORES = 1500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SCORE_W-1:0]    s_axis_tdata = '0;   // [15:0] score
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [5:0] keypoint_index, [21:6] peak_score, [34:22] pos_x, [47:35] pos_y
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;        // [0] found
  logic                  m_axis_tlast;

  int pending_peaks;
  int mismatches;

  int send_idle_pct = 8;
  int recv_idle_pct = 81;
  int hold_gen = 0;
  int scores_sent = 0;

  logic [DIM_W-1:0]          rows_now = 9'd64;
  logic [DIM_W-1:0]          cols_now = 9'd48;
  logic signed [SCORE_W-1:0] thr_now = '0;

  always #5 clk = ~clk;

  heatmap_keypoint_argmax_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  heatmap_keypoint_argmax_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_peaks (pending_peaks),
    .mismatches    (mismatches)
  );

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        // long hold-off so the record queue backs up into s_axis
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_score(input logic [SCORE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    scores_sent++;
  endtask

  task automatic stream_pause();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained(input int pad);
    do @(posedge clk); while (pending_peaks != 0);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w,
                           input logic [IMG_W-1:0] iw, input logic [IMG_W-1:0] ih,
                           input logic [SCORE_W-1:0] thr);
    write_reg(REG_MAP_HEIGHT, 32'(h));
    write_reg(REG_MAP_WIDTH, 32'(w));
    write_reg(REG_IMAGE_WIDTH, 32'(iw));
    write_reg(REG_IMAGE_HEIGHT, 32'(ih));
    write_reg(REG_THRESHOLD, 32'(thr));
    apb_release();
    rows_now = h;
    cols_now = w;
    thr_now  = thr;
  endtask

  function automatic int map_extent(input logic [DIM_W-1:0] d);
    return (d == '0) ? 1 : (d > MAX_MAP_DIM_DEF) ? MAX_MAP_DIM_DEF : int'(d);
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(4))
      0: return SCORE_W'($urandom);
      1: return thr_now + SCORE_W'($urandom_range(4)) - 16'd2;
      // narrow range so equal maxima are common
      2: return SCORE_W'($urandom_range(3));
      3: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return thr_now + SCORE_W'($urandom_range(300));
    endcase
  endfunction

  function automatic logic [IMG_W-1:0] pick_image_dim();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 13'd4096;
      3: return 13'd1;
      default: return IMG_W'($urandom_range(4096, 1));
    endcase
  endfunction

  task automatic send_channels(input int n, input bit peak_at_end);
    int len;
    logic [SCORE_W-1:0] v;
    len = map_extent(rows_now) * map_extent(cols_now);
    for (int ch = 0; ch < n; ch++) begin
      for (int k = 0; k < len; k++) begin
        if (peak_at_end) begin
          // the peak sits on the far corner of a wide or tall map
          v = (k == len - 1) ? 16'h7fff : SCORE_W'($urandom_range(200)) - 16'd100;
        end else begin
          v = pick_score();
        end
        send_score(v);
      end
      if (ch < n - 1 && $urandom_range(7) == 0) begin
        stream_pause();
        wait_drained(0);
      end
    end
  endtask

  initial begin : stimulus
    logic [SCORE_W-1:0] opening[12] = '{16'h8000, 16'h7fff, 16'h0005, 16'h7fff,
                                        16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        16'h0000, 16'h0000, 16'h0000, 16'h0000};
    logic [DIM_W-1:0]   h;
    logic [DIM_W-1:0]   w;
    logic [SCORE_W-1:0] thr;
    int directed_sent;
    int phase;
    int bigs_done;
    int nch;
    int rnd;
    bit big;
    bit hold;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x2 maps: clamped image width, zero image height, ties, all-minimum, equal to threshold
    configure(9'd2, 9'd2, '1, '0, 16'h0000);
    foreach (opening[i]) begin
      send_score(opening[i]);
    end
    stream_pause();
    wait_drained(SETTLE_CYCLES);

    // zero map size acts as one, threshold at the minimum
    configure('0, '0, 13'd1, 13'd4096, 16'h8000);
    send_score(16'h8000);
    send_score(16'h8001);
    stream_pause();
    wait_drained(SETTLE_CYCLES);

    // width shrunk in the middle of a row
    configure(9'd1, 9'd5, 13'd4096, 13'd4096, 16'hffff);
    for (int k = 0; k < 4; k++) begin
      send_score(SCORE_W'(k));
    end
    stream_pause();
    wait_drained(SETTLE_CYCLES);
    write_reg(REG_MAP_WIDTH, 32'd2);
    apb_release();
    send_score(16'h0000);
    stream_pause();
    wait_drained(SETTLE_CYCLES);

    // height shrunk in the middle of a channel
    configure(9'd4, 9'd1, 13'd4095, 13'd3000, 16'h0000);
    for (int k = 0; k < 3; k++) begin
      send_score(SCORE_W'(k + 1));
    end
    stream_pause();
    wait_drained(SETTLE_CYCLES);
    write_reg(REG_MAP_HEIGHT, 32'd2);
    apb_release();
    send_score(16'h0004);

    directed_sent = scores_sent;
    phase = 0;
    bigs_done = 0;
    while (scores_sent < directed_sent + RANDOM_SCORES) begin
      rnd = scores_sent - directed_sent;
      if (rnd < RANDOM_SCORES / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 81;
      end else if (rnd < 2 * RANDOM_SCORES / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      big  = (bigs_done < 3) && (phase % 4 == 2);
      hold = (phase == 1) || (phase % 6 == 5);
      if (big) begin
        case (bigs_done)
          0: begin h = 9'd511; w = 9'd1; end
          1: begin h = 9'd0;   w = 9'd256; end
          default: begin h = 9'd257; w = 9'd0; end
        endcase
        nch = 1;
        bigs_done++;
      end else if (hold) begin
        h = DIM_W'($urandom_range(1));
        w = DIM_W'($urandom_range(2, 1));
        nch = 30;
      end else if ($urandom_range(5) == 0) begin
        h = DIM_W'($urandom_range(16, 5));
        w = DIM_W'($urandom_range(16, 5));
        nch = 1;
      end else begin
        h = DIM_W'($urandom_range(4));
        w = DIM_W'($urandom_range(6));
        nch = $urandom_range(20, 3);
      end
      case ($urandom_range(6))
        0: thr = 16'h8000;
        1: thr = 16'h7fff;
        2: thr = 16'hffff;
        3: thr = 16'h0000;
        4: thr = SCORE_W'($urandom);
        default: thr = SCORE_W'($urandom_range(511)) - 16'd256;
      endcase

      // registers change only with the pipeline empty and no channel half done
      stream_pause();
      wait_drained(SETTLE_CYCLES);
      configure(h, w, pick_image_dim(), pick_image_dim(), thr);
      if (hold) begin
        hold_gen <= hold_gen + 1;
      end
      send_channels(nch, big);
      phase++;
    end

    stream_pause();
    wait_drained(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
